// ----- sv/trf_pkg.sv -----
// package for the two-group rank fraction block
// field widths, entry and link types, control struct and the ordering key
// no dependencies
package trf_pkg;

  localparam int DEF_SET_CAPACITY = 64;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;
  localparam int FRAC_W = 16;
  localparam int ADDR_W = 3;

  localparam logic REG_VALUE_FORMAT = 1'b0;

  typedef struct packed {
    logic [VAL_W-1:0] key;
    logic             grp;
  } entry_t;

  typedef struct packed {
    logic   valid;
    logic   gt;
    entry_t entry;
  } link_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] bits,
                                                 input logic fmt);
    logic [VAL_W-1:0] b;
    b = bits;
    if (!fmt) begin
      return {16'h0000, bits[15:0]};
    end
    if (b == 32'h8000_0000) begin
      b = '0;
    end
    if (b[31]) begin
      return ~b;
    end
    return b | 32'h8000_0000;
  endfunction

endpackage

// ----- sv/trf_cell.sv -----
// one sorting cell of the chain: holds one entry, inserts in order, shifts down on drain
// depends on trf_pkg
module trf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  trf_pkg::cell_ctrl_t ctrl,
  input  trf_pkg::entry_t    new_entry,
  input  trf_pkg::link_t     prev_link,
  input  trf_pkg::link_t     next_link,
  output trf_pkg::link_t     link
);

  logic            valid_r, valid_nxt;
  trf_pkg::entry_t entry_r, entry_nxt;
  logic            gt;

  assign gt = valid_r && (entry_r > new_entry);

  always_comb begin
    valid_nxt = valid_r;
    entry_nxt = entry_r;
    if (ctrl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      valid_nxt = next_link.valid;
      entry_nxt = next_link.entry;
    end else if (ctrl.ins) begin
      if (prev_link.gt) begin
        valid_nxt = 1'b1;
        entry_nxt = prev_link.entry;
      end else if (prev_link.valid && (gt || !valid_r)) begin
        valid_nxt = 1'b1;
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign link.valid = valid_r;
  assign link.gt    = gt;
  assign link.entry = entry_r;

endmodule

// ----- sv/trf_div.sv -----
// serial restoring divider: floor(pos * 2^16 / count), one quotient bit per cycle
// depends on trf_pkg
module trf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [trf_pkg::POS_W-1:0]  pos,
  input  logic [trf_pkg::CNT_W-1:0]  count,
  output logic                       done,
  output logic [trf_pkg::FRAC_W-1:0] quotient
);

  localparam int STEP_W = $clog2(trf_pkg::FRAC_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [trf_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [trf_pkg::CNT_W-1:0]  den_r, den_nxt;
  logic [trf_pkg::FRAC_W-1:0] quo_r, quo_nxt;
  logic [trf_pkg::CNT_W:0]    shifted;
  logic [trf_pkg::CNT_W:0]    diff;
  logic                       fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, pos};
      den_nxt  = count;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[trf_pkg::CNT_W-1:0] : shifted[trf_pkg::CNT_W-1:0];
      quo_nxt  = {quo_r[trf_pkg::FRAC_W-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(trf_pkg::FRAC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/two_group_rank_fraction.sv -----
// top level of the two-group rank fraction block: cell chain, drain sequencer, divider, apb
// depends on trf_pkg, trf_cell, trf_div
//
// While a set loads, one word is accepted every cycle and, below SET_CAPACITY entries,
// inserted in sorted order by a chain of SET_CAPACITY cells; each cell compares the
// broadcast entry with its own and shifts up in the same cycle. After the word flagged
// last, the chain drains toward cell 0: a group-0 entry is shifted out by the scan state,
// a group-1 entry passes through the scan state, the serial Q0.16 divider, a handoff and
// the emit state, plus any output stall. Then the set is cleared and input is accepted
// again, not during the drain. value_format is written through the apb port at address 0.
module two_group_rank_fraction #(
  parameter int SET_CAPACITY = trf_pkg::DEF_SET_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [trf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [trf_pkg::VAL_W-1:0]   in_sample_value,
  input  logic                        in_group_tag,
  input  logic                        in_last_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [trf_pkg::POS_W-1:0]   out_rank_position,
  output logic [trf_pkg::CNT_W-1:0]   out_total_count,
  output logic [trf_pkg::FRAC_W-1:0]  out_rank_fraction,
  output logic                        out_overflow_flag,
  output logic                        out_last_result
);

  localparam logic [trf_pkg::CNT_W-1:0] CAP = trf_pkg::CNT_W'(SET_CAPACITY);

  logic                      fmt_r;
  trf_pkg::state_t           state_r, state_nxt;
  logic [trf_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [trf_pkg::CNT_W-1:0] ones_r, ones_nxt;
  logic [trf_pkg::CNT_W-1:0] pos_r, pos_nxt;
  logic [trf_pkg::CNT_W-1:0] emitted_r, emitted_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [trf_pkg::POS_W-1:0]  o_pos_r, o_pos_nxt;
  logic [trf_pkg::CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [trf_pkg::FRAC_W-1:0] o_frac_r, o_frac_nxt;
  logic                       o_ovf_r, o_ovf_nxt;
  logic                       o_last_r, o_last_nxt;

  trf_pkg::cell_ctrl_t ctrl;
  trf_pkg::entry_t     new_entry;
  trf_pkg::link_t      cell_q [SET_CAPACITY];
  trf_pkg::link_t      head_link;
  trf_pkg::link_t      tail_link;

  logic                       accept;
  logic                       div_start;
  logic                       div_done;
  logic [trf_pkg::FRAC_W-1:0] div_quo;
  logic                       cfg_wr;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= 1'b0;
    end else if (cfg_wr && (paddr[2] == trf_pkg::REG_VALUE_FORMAT)) begin
      fmt_r <= pwdata[0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      trf_pkg::REG_VALUE_FORMAT: prdata = {31'h0, fmt_r};
      default:                   prdata = '0;
    endcase
  end

  // cell chain
  assign new_entry.key = trf_pkg::order_key(in_sample_value, fmt_r);
  assign new_entry.grp = in_group_tag;

  assign head_link = '{valid: 1'b1, gt: 1'b0, entry: '0};
  assign tail_link = '{valid: 1'b0, gt: 1'b0, entry: '0};

  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    trf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .new_entry (new_entry),
      .prev_link ((i == 0) ? head_link : cell_q[(i == 0) ? 0 : i - 1]),
      .next_link ((i == SET_CAPACITY - 1) ? tail_link :
                  cell_q[(i == SET_CAPACITY - 1) ? i : i + 1]),
      .link      (cell_q[i])
    );
  end

  trf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .pos      (pos_r[trf_pkg::POS_W-1:0]),
    .count    (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ready = (state_r == trf_pkg::S_LOAD);
  assign accept   = in_valid && in_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ones_nxt      = ones_r;
    pos_nxt       = pos_r;
    emitted_nxt   = emitted_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_pos_nxt     = o_pos_r;
    o_cnt_nxt     = o_cnt_r;
    o_frac_nxt    = o_frac_r;
    o_ovf_nxt     = o_ovf_r;
    o_last_nxt    = o_last_r;
    ctrl          = '{ins: 1'b0, shift: 1'b0, clr: 1'b0};
    div_start     = 1'b0;
    unique case (state_r)
      trf_pkg::S_LOAD: begin
        if (accept) begin
          if (count_r < CAP) begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + 1'b1;
            if (in_group_tag) begin
              ones_nxt = ones_r + 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_sample) begin
            state_nxt   = trf_pkg::S_SCAN;
            pos_nxt     = '0;
            emitted_nxt = '0;
          end
        end
      end
      trf_pkg::S_SCAN: begin
        if (pos_r == count_r) begin
          ctrl.clr  = 1'b1;
          count_nxt = '0;
          ones_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = trf_pkg::S_LOAD;
        end else if (cell_q[0].entry.grp) begin
          div_start = 1'b1;
          state_nxt = trf_pkg::S_DIV;
        end else begin
          ctrl.shift = 1'b1;
          pos_nxt    = pos_r + 1'b1;
        end
      end
      trf_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = trf_pkg::S_EMIT;
        end
      end
      trf_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_pos_nxt     = pos_r[trf_pkg::POS_W-1:0];
          o_cnt_nxt     = count_r;
          o_frac_nxt    = div_quo;
          o_ovf_nxt     = ovf_r;
          o_last_nxt    = ((emitted_r + 1'b1) == ones_r);
          ctrl.shift    = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          emitted_nxt   = emitted_r + 1'b1;
          state_nxt     = trf_pkg::S_SCAN;
        end
      end
      default: begin
        state_nxt = trf_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= trf_pkg::S_LOAD;
      count_r     <= '0;
      ones_r      <= '0;
      pos_r       <= '0;
      emitted_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ones_r      <= ones_nxt;
      pos_r       <= pos_nxt;
      emitted_r   <= emitted_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_pos_r  <= o_pos_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_frac_r <= o_frac_nxt;
    o_ovf_r  <= o_ovf_nxt;
    o_last_r <= o_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rank_position = o_pos_r;
  assign out_total_count   = o_cnt_r;
  assign out_rank_fraction = o_frac_r;
  assign out_overflow_flag = o_ovf_r;
  assign out_last_result   = o_last_r;

endmodule
